// File: rtl/ascii_to_unsigned_parser_top_defines.svh
// Assertion macros used by the checker module.
`ifndef ASCII_TO_UNSIGNED_PARSER_TOP_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ATU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ATU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/atu_pkg.sv
`default_nettype none

package atu_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A_LO  = 8'h61;
  localparam logic [7:0] CHAR_Z_LO  = 8'h7a;
  localparam logic [7:0] CHAR_A_UP  = 8'h41;
  localparam logic [7:0] CHAR_Z_UP  = 8'h5a;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  // Radix codes
  localparam int unsigned BASE_W = 6;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;
  // Never below any radix, so it is never taken as a digit
  localparam logic [BASE_W-1:0] NO_DIGIT   = 6'h3f;

  localparam int unsigned OUT_VALUE_W = 64;
  localparam int unsigned CONSUMED_W  = 8;

  typedef enum logic [5:0] {
    PH_WS     = 6'b000001,
    PH_PREFIX = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_HEXX   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic                minus_seen;
    logic [BASE_W-1:0]   active_base;
  } ctl_t;

  typedef struct packed {
    logic       start_req;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic [CONSUMED_W-1:0]  consumed;
  } out_item_t;

  function automatic logic [BASE_W-1:0] digit_val(input logic [7:0] c);
    logic [BASE_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = BASE_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_A_LO && c <= CHAR_Z_LO) begin
      d = BASE_W'(c - CHAR_A_LO + 8'd10);
    end else if (c >= CHAR_A_UP && c <= CHAR_Z_UP) begin
      d = BASE_W'(c - CHAR_A_UP + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
           (c == CHAR_LF) || (c == CHAR_FF) || (c == CHAR_VT);
  endfunction

endpackage

`default_nettype wire

// File: rtl/atu_step.sv
`default_nettype none

module atu_step import atu_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_LEN     = 255,
  parameter int unsigned CNT_W       = 8
) (
  input  wire  logic                   start_i,
  input  wire  logic [7:0]             char_i,
  input  wire  logic [BASE_W-1:0]      number_base_i,
  input  wire  ctl_t                   ctl_i,
  input  wire  logic [VALUE_WIDTH-1:0] acc_i,
  input  wire  logic [CNT_W-1:0]       cnt_i,
  output ctl_t                         ctl_o,
  output logic [VALUE_WIDTH-1:0]       acc_o,
  output logic [CNT_W-1:0]             cnt_o,
  output logic                         emit_o,
  output out_item_t                    result_o
);

  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] MaxLenC = SUM_W'(MAX_LEN);

  ctl_t                   ctl_cur;
  logic [VALUE_WIDTH-1:0] acc_cur;
  logic [CNT_W-1:0]       cnt_cur;
  logic [BASE_W-1:0]      dig;
  logic [BASE_W-1:0]      mul_base;
  logic                   do_acc;
  logic [1:0]             inc;
  logic                   have_digits;
  logic [VALUE_WIDTH+5:0] prod;
  logic [VALUE_WIDTH-1:0] val;
  logic [SUM_W-1:0]       cnt_sum;
  logic [CNT_W+7:0]       cnt_ext;

  // Start of a new string clears the parser state first
  assign ctl_cur = start_i ? ctl_t'{phase: PH_WS, minus_seen: 1'b0, active_base: BASE_AUTO}
                           : ctl_i;
  assign acc_cur = start_i ? '0 : acc_i;
  assign cnt_cur = start_i ? '0 : cnt_i;
  assign dig     = digit_val(char_i);

  // Decide what this character does
  always_comb begin
    logic prefix_path;
    logic digit_path;
    prefix_path = 1'b0;
    digit_path  = 1'b0;
    ctl_o       = ctl_cur;
    mul_base    = ctl_cur.active_base;
    do_acc      = 1'b0;
    inc         = 2'd0;
    have_digits = 1'b1;
    emit_o      = 1'b0;

    unique case (ctl_cur.phase)
      PH_WS: begin
        if (is_space(char_i)) begin
          inc = 2'd1;
        end else if (char_i == CHAR_MINUS || char_i == CHAR_PLUS) begin
          ctl_o.minus_seen = (char_i == CHAR_MINUS);
          ctl_o.phase      = PH_PREFIX;
          inc              = 2'd1;
        end else begin
          prefix_path = 1'b1;
        end
      end
      PH_PREFIX: prefix_path = 1'b1;
      PH_ZERO: begin
        if (char_i == CHAR_X_LO) begin
          ctl_o.active_base = BASE_HEX;
          ctl_o.phase       = PH_HEXX;
        end else begin
          mul_base   = (ctl_cur.active_base == BASE_AUTO) ? BASE_OCT : ctl_cur.active_base;
          digit_path = 1'b1;
        end
      end
      PH_HEXX: begin
        mul_base = BASE_HEX;
        if (dig < BASE_HEX) begin
          do_acc      = 1'b1;
          inc         = 2'd2;
          ctl_o.phase = PH_DIGITS;
        end else begin
          emit_o      = 1'b1;
          ctl_o.phase = PH_DONE;
        end
      end
      PH_DIGITS: digit_path = 1'b1;
      PH_DONE: ;
      default: ;
    endcase

    // Sign or prefix stage: sample the configured radix
    if (prefix_path) begin
      ctl_o.active_base = number_base_i;
      if (char_i == CHAR_ZERO &&
          (number_base_i == BASE_AUTO || number_base_i == BASE_HEX)) begin
        inc         = 2'd1;
        ctl_o.phase = PH_ZERO;
      end else begin
        mul_base    = (number_base_i == BASE_AUTO) ? BASE_DEC : number_base_i;
        digit_path  = 1'b1;
        have_digits = 1'b0;
      end
    end

    // Take a digit below the radix, or stop
    if (digit_path) begin
      ctl_o.active_base = mul_base;
      if (dig < mul_base) begin
        do_acc      = 1'b1;
        inc         = 2'd1;
        ctl_o.phase = PH_DIGITS;
      end else begin
        emit_o      = 1'b1;
        ctl_o.phase = PH_DONE;
      end
    end
  end

  // Accumulate: one narrow multiply by the radix plus the digit
  assign prod  = acc_cur * mul_base;
  assign acc_o = do_acc ? (prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig)) : acc_cur;

  // Advance the character count, saturating
  assign cnt_sum = {1'b0, cnt_cur} + SUM_W'(inc);
  assign cnt_o   = (cnt_sum > MaxLenC) ? MaxLenC[CNT_W-1:0] : cnt_sum[CNT_W-1:0];

  // Result word: negate on a minus sign, zero when no digit was seen
  assign val     = ctl_cur.minus_seen ? ('0 - acc_cur) : acc_cur;
  assign cnt_ext = {8'h00, cnt_cur};
  assign result_o.value    = have_digits ? OUT_VALUE_W'(val) : '0;
  assign result_o.consumed = have_digits ? cnt_ext[CONSUMED_W-1:0] : '0;

endmodule

`default_nettype wire

// File: rtl/ascii_to_unsigned_parser_top.sv
// A stopping character waits in the input register; its result word is then
// loaded into the result register and shown as valid.
// Throughput: one character per cycle; the input stalls only while the result
// register holds a word that the receiver has not yet taken.
// Reset (asynchronous, active low): radix register to 10, parser to whitespace
// skip with accumulator, sign, radix and count cleared; both stages empty.
`default_nettype none

module ascii_to_unsigned_parser_top import atu_pkg::*; #(
  parameter int unsigned MAX_LEN     = 255,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  logic [BASE_W-1:0] cfg_data_i,
  input  wire  logic              in_valid_i,
  output logic                    in_ready_o,
  input  wire  in_item_t          in_data_i,
  output logic                    out_valid_o,
  input  wire  logic              out_ready_i,
  output out_item_t               out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [BASE_W-1:0]      number_base_q;
  logic                   in_valid_q;
  in_item_t               in_q;
  ctl_t                   ctl_q;
  ctl_t                   ctl_d;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [VALUE_WIDTH-1:0] acc_d;
  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       cnt_d;
  logic                   emit;
  out_item_t              result;
  logic                   out_valid_q;
  out_item_t              out_q;
  logic                   proc_fire;

  assign cfg_ready_o = 1'b1;

  // Hold the radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      number_base_q <= cfg_data_i;
    end
  end

  // A held word is processed once the result register can take its result
  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  atu_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_LEN     (MAX_LEN),
    .CNT_W       (CNT_W)
  ) u_step (
    .start_i       (in_q.start_req),
    .char_i        (in_q.char_in),
    .number_base_i (number_base_q),
    .ctl_i         (ctl_q),
    .acc_i         (acc_q),
    .cnt_i         (cnt_q),
    .ctl_o         (ctl_d),
    .acc_o         (acc_d),
    .cnt_o         (cnt_d),
    .emit_o        (emit),
    .result_o      (result)
  );

  // Parser state, advanced once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{phase: PH_WS, minus_seen: 1'b0, active_base: BASE_AUTO};
      acc_q <= '0;
      cnt_q <= '0;
    end else if (proc_fire) begin
      ctl_q <= ctl_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // Result register: load on a stop, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/atu_checker.sv
`default_nettype none
`include "ascii_to_unsigned_parser_top_defines.svh"

module atu_checker import atu_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_ready_o,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire out_item_t         out_data_o
);

  // A stalled result word holds
  `ATU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // No result is shown straight after a reset edge
  `ATU_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid straight after reset")

  // An empty result register never blocks the input side
  `ATU_ASSERT(a_in_open, !out_valid_o |-> in_ready_o, "input stalled with empty result register")

  // A result being taken frees the path for the next character
  `ATU_ASSERT(a_drain_ready, out_valid_o && out_ready_i |-> in_ready_o && cfg_ready_o, "input stalled while result drains")

endmodule

bind ascii_to_unsigned_parser_top atu_checker u_atu_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import atu_pkg::*;

  localparam int unsigned MAX_LEN     = 255;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEG_ITEMS   = 110;
  localparam int unsigned NUM_SEGS    = 9;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [BASE_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;

  ascii_to_unsigned_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Characters waiting to be sent, and conversions still owed by the block
  in_item_t    chars_to_send[$];
  out_item_t   conversions_due[$];
  bit          fresh = 1'b0;
  int unsigned items_queued = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  bit          char_taken = 1'b0;

  logic [7:0] blanks [6] = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF, CHAR_FF, CHAR_VT};
  logic [BASE_W-1:0] seg_base [NUM_SEGS] =
    '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_OCT, 6'd1, 6'd36, 6'd63, 6'd2, BASE_DEC};

  // Parser state as the block should hold it
  logic [BASE_W-1:0] base_setting = BASE_RESET;
  phase_e            cur_phase    = PH_WS;
  logic [63:0]       acc_value    = '0;
  logic              neg_sign     = 1'b0;
  logic [BASE_W-1:0] run_base     = '0;
  int unsigned       run_count    = 0;

  function automatic int unsigned char_weight(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
    if (c >= CHAR_A_LO && c <= CHAR_Z_LO) return c - CHAR_A_LO + 10;
    if (c >= CHAR_A_UP && c <= CHAR_Z_UP) return c - CHAR_A_UP + 10;
    return 255;
  endfunction

  task automatic add_count(input int unsigned n);
    run_count = (run_count + n > MAX_LEN) ? MAX_LEN : run_count + n;
  endtask

  // Close the conversion and owe one word
  task automatic finish_number(input bit have_digits);
    out_item_t   w;
    logic [63:0] v;
    v = neg_sign ? (64'd0 - acc_value) : acc_value;
    w.value    = have_digits ? v : '0;
    w.consumed = have_digits ? 8'(run_count) : '0;
    conversions_due.push_back(w);
    cur_phase = PH_DONE;
  endtask

  task automatic absorb_digit(input logic [7:0] c, input bit have_digits);
    int unsigned d;
    d = char_weight(c);
    if (d < run_base) begin
      acc_value = acc_value * 64'(run_base) + 64'(d);
      add_count(1);
      cur_phase = PH_DIGITS;
    end else begin
      finish_number(have_digits);
    end
  endtask

  // Latch the radix and look for a leading zero
  task automatic open_number(input logic [7:0] c);
    run_base = base_setting;
    if (c == CHAR_ZERO && (run_base == BASE_AUTO || run_base == BASE_HEX)) begin
      acc_value = '0;
      add_count(1);
      cur_phase = PH_ZERO;
    end else begin
      if (run_base == BASE_AUTO) run_base = BASE_DEC;
      absorb_digit(c, 1'b0);
    end
  endtask

  task automatic parse_char(input in_item_t w);
    logic [7:0]  c;
    int unsigned d;
    c = w.char_in;
    if (w.start_req) begin
      cur_phase = PH_WS;
      acc_value = '0;
      neg_sign  = 1'b0;
      run_base  = '0;
      run_count = 0;
    end
    case (cur_phase)
      PH_WS: begin
        if (c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF, CHAR_FF, CHAR_VT}) begin
          add_count(1);
        end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
          neg_sign = (c == CHAR_MINUS);
          add_count(1);
          cur_phase = PH_PREFIX;
        end else begin
          open_number(c);
        end
      end
      PH_PREFIX: open_number(c);
      PH_ZERO: begin
        if (c == CHAR_X_LO) begin
          run_base  = BASE_HEX;
          cur_phase = PH_HEXX;
        end else begin
          if (run_base == BASE_AUTO) run_base = BASE_OCT;
          absorb_digit(c, 1'b1);
        end
      end
      PH_HEXX: begin
        d = char_weight(c);
        if (d < 16) begin
          acc_value = acc_value * 64'd16 + 64'(d);
          add_count(2);
          cur_phase = PH_DIGITS;
        end else begin
          finish_number(1'b1);
        end
      end
      PH_DIGITS: absorb_digit(c, 1'b1);
      default: ;
    endcase
  endtask

  // Stimulus helpers
  task automatic put(input logic [7:0] c);
    in_item_t w;
    w.start_req = fresh;
    w.char_in   = c;
    chars_to_send.push_back(w);
    fresh = 1'b0;
    items_queued++;
  endtask

  task automatic put_text(input string s);
    fresh = 1'b1;
    foreach (s[i]) put(s[i]);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(1) ? CHAR_A_UP : CHAR_A_LO) + 8'(d - 10);
  endfunction

  // One string: mostly well formed, some noise
  task automatic add_string(input logic [BASE_W-1:0] b);
    int unsigned n;
    int unsigned r;
    int unsigned gen_base;
    if ($urandom_range(99) < 12) begin
      fresh = 1'b1;
      put(8'($urandom));
      repeat ($urandom_range(1, 8)) begin
        fresh = ($urandom_range(4) == 0);
        put(8'($urandom));
      end
      return;
    end
    fresh = 1'b1;
    repeat ($urandom_range(0, 2)) put(blanks[$urandom_range(5)]);
    r = $urandom_range(5);
    if (r == 0) put(CHAR_MINUS);
    else if (r == 1) put(CHAR_PLUS);
    if ($urandom_range(19) == 0) put(CHAR_MINUS);
    gen_base = (b == BASE_AUTO) ? 10 : b;
    if (b == BASE_AUTO || b == BASE_HEX) begin
      r = $urandom_range(5);
      if (r <= 1) begin
        put(CHAR_ZERO);
        put(CHAR_X_LO);
        gen_base = 16;
      end else if (r == 2) begin
        put(CHAR_ZERO);
        if (b == BASE_AUTO) gen_base = 8;
      end else if (r == 3) begin
        put(CHAR_ZERO);
        put("X");
      end
    end
    if (gen_base > 36) gen_base = 36;
    n = ($urandom_range(9) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 8);
    repeat (n) put(digit_char($urandom_range(gen_base - 1)));
    // stopping character
    r = $urandom_range(7);
    if (r <= 3) put(8'h00);
    else if (r == 4) put(8'($urandom));
    else if (r == 5) put(blanks[$urandom_range(5)]);
    else if (r == 6) put(digit_char($urandom_range(35)));
    else put(CHAR_PLUS);
    // trailing characters the block should drop
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom));
  endtask

  task automatic settle();
    while (chars_to_send.size() != 0 || in_valid_i || conversions_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    base_setting = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Record accepted characters and predict their conversions
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      parse_char(in_data_i);
      char_taken = 1'b1;
    end
  end

  // Drive the next character once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || char_taken)) begin
      if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= chars_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    char_taken = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = 400;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result word with the oldest conversion owed
  always @(posedge clk_i) begin
    out_item_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (conversions_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected word: value %h consumed %0d",
                   out_data_o.value, out_data_o.consumed);
        fault_count++;
      end else begin
        due = conversions_due.pop_front();
        if (out_data_o.value !== due.value || out_data_o.consumed !== due.consumed) begin
          if (fault_count < 10)
            $display("mismatch: expected value %h consumed %0d, got value %h consumed %0d",
                     due.value, due.consumed, out_data_o.value, out_data_o.consumed);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s != 0) begin
        settle();
        write_base(seg_base[s]);
      end
      // idling schedule: sender light and receiver heavy, then swapped, then none
      send_idle_pct = (s < 3) ? 37 : (s < 6) ? 57 : 0;
      recv_idle_pct = (s < 3) ? 57 : (s < 6) ? 37 : 0;
      mark = items_queued;

      // directed strings for the radix in use
      if (s == 0) begin
        fresh = 1'b1;
        foreach (blanks[i]) put(blanks[i]);
        put(CHAR_MINUS);
        put("4");
        put("2");
        put(8'h00);
        put_text("+-5");
        put_text("7");
        put(8'hff);
        put("a");
        fresh = 1'b1;
        put(8'h00);
      end else if (seg_base[s] == BASE_AUTO) begin
        put_text("0xg");
        put_text("0X1");
        put_text("-0x1F ");
      end else if (seg_base[s] == BASE_HEX) begin
        put_text("0xG");
      end
      // one string long enough to wrap the value and saturate the count
      if (s == NUM_SEGS - 1) begin
        fresh = 1'b1;
        put("1");
        repeat (269) put("7");
        put(8'h00);
      end
      while (items_queued - mark < SEG_ITEMS) add_string(seg_base[s]);
      // back-pressure the output so the block fills and stalls its input
      if (s == NUM_SEGS - 2) hold_request = 1'b1;
    end

    settle();
    if (fault_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
